>>> rtl/core/vpid_pkg.sv
// Shared widths, register indexes and the configuration struct of the velocity PID controller.
package vpid_pkg;

	localparam int SAMPLE_W  = 16;  // measurement and setpoint, signed Q12.4
	localparam int MEAS_FRAC = 4;
	localparam int GAIN_W    = 16;  // gains, unsigned Q8.8
	localparam int GAIN_FRAC = 8;
	localparam int COUNT_W   = 16;
	localparam int LEVEL_W   = 7;
	localparam int LEVEL_MAX = 100;
	localparam int DELTA_LIM = 2 * LEVEL_MAX;

	// error terms carry two extra bits (second difference of the history)
	localparam int ERR_W  = SAMPLE_W + 2;
	localparam int PROD_W = ERR_W + GAIN_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SHIFT  = GAIN_FRAC + MEAS_FRAC;
	localparam int DEL_W  = ACC_W - SHIFT;
	localparam int SUM_W  = LEVEL_W + 3;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = CFG_IDX_W'(3);

	localparam logic [GAIN_W-1:0]  GAIN_P_RST        = GAIN_W'(256);
	localparam logic [GAIN_W-1:0]  GAIN_I_RST        = GAIN_W'(0);
	localparam logic [GAIN_W-1:0]  GAIN_D_RST        = GAIN_W'(0);
	localparam logic [COUNT_W-1:0] SAMPLE_PERIOD_RST = COUNT_W'(5);

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [COUNT_W-1:0] sample_period;
	} cfg_t;

endpackage

>>> rtl/core/vpid_cfg_regs.sv
// Configuration register file of the velocity PID controller.
module vpid_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vpid_pkg::CFG_DATA_W-1:0]  cfg_data,
	output vpid_pkg::cfg_t                   cfg
);

	vpid_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// unknown indexes drop the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= vpid_pkg::GAIN_P_RST;
			cfg_q.gain_i        <= vpid_pkg::GAIN_I_RST;
			cfg_q.gain_d        <= vpid_pkg::GAIN_D_RST;
			cfg_q.sample_period <= vpid_pkg::SAMPLE_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vpid_pkg::REG_GAIN_P:        cfg_q.gain_p        <= cfg_data;
				vpid_pkg::REG_GAIN_I:        cfg_q.gain_i        <= cfg_data;
				vpid_pkg::REG_GAIN_D:        cfg_q.gain_d        <= cfg_data;
				vpid_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/vpid_law.sv
// Velocity-form control law: three gain products, floor shift and level clamp.
module vpid_law (
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] x,
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] sp,
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] prev,
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] older,
	input  logic [vpid_pkg::LEVEL_W-1:0]         level,
	input  logic                                 en,
	input  vpid_pkg::cfg_t                       cfg,
	output logic [vpid_pkg::LEVEL_W-1:0]         level_next
);

	localparam int ErrW  = vpid_pkg::ERR_W;
	localparam int ProdW = vpid_pkg::PROD_W;
	localparam int AccW  = vpid_pkg::ACC_W;
	localparam int DelW  = vpid_pkg::DEL_W;
	localparam int SumW  = vpid_pkg::SUM_W;
	localparam int GainW = vpid_pkg::GAIN_W;
	localparam int Shift = vpid_pkg::SHIFT;

	localparam logic signed [DelW-1:0] DeltaHi = DelW'(vpid_pkg::DELTA_LIM);
	localparam logic signed [DelW-1:0] DeltaLo = -DeltaHi;
	localparam logic signed [SumW-1:0] SumMax  = SumW'(vpid_pkg::LEVEL_MAX);
	localparam logic [vpid_pkg::LEVEL_W-1:0] LevelMax =
		vpid_pkg::LEVEL_W'(vpid_pkg::LEVEL_MAX);

	logic signed [ErrW-1:0]  x_e, sp_e, prev_e, older_e;
	logic signed [ErrW-1:0]  err_p, err_i, err_d;
	logic signed [GainW:0]   kp, ki, kd;
	logic signed [ProdW-1:0] prod_p, prod_i, prod_d;
	logic signed [AccW-1:0]  acc;
	logic signed [AccW-1:0]  acc_sh;
	logic signed [DelW-1:0]  delta_full;
	logic signed [SumW-1:0]  delta_c;
	logic signed [SumW-1:0]  level_e;
	logic signed [SumW-1:0]  sum;

	assign x_e     = ErrW'(x);
	assign sp_e    = ErrW'(sp);
	assign prev_e  = ErrW'(prev);
	assign older_e = ErrW'(older);

	// proportional and derivative act on the measurement only
	assign err_p = prev_e - x_e;
	assign err_i = sp_e - x_e;
	assign err_d = (prev_e <<< 1) - x_e - older_e;

	assign kp = signed'({1'b0, cfg.gain_p});
	assign ki = signed'({1'b0, cfg.gain_i});
	assign kd = signed'({1'b0, cfg.gain_d});

	assign prod_p = kp * err_p;
	assign prod_i = ki * err_i;
	assign prod_d = kd * err_d;

	assign acc        = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);
	assign acc_sh     = acc >>> Shift;
	assign delta_full = acc_sh[DelW-1:0];
	assign level_e    = signed'(SumW'(level));

	always_comb begin
		if (delta_full > DeltaHi) begin
			delta_c = SumW'(DeltaHi);
		end else if (delta_full < DeltaLo) begin
			delta_c = SumW'(DeltaLo);
		end else begin
			delta_c = delta_full[SumW-1:0];
		end
		sum = level_e + delta_c;
		if (!en) begin
			level_next = '0;
		end else if (sum < 0) begin
			level_next = '0;
		end else if (sum > SumMax) begin
			level_next = LevelMax;
		end else begin
			level_next = sum[vpid_pkg::LEVEL_W-1:0];
		end
	end

endmodule

>>> rtl/core/velocity_pid_controller.sv
// Velocity-form PID controller: top level with input, state and result registers.
//
// One input transfer is one tick carrying measurement, setpoint and enable.
// Every tick gives exactly one result: drive_level (0..100) and updated,
// which is high when the tick ran a controller update. An update runs once
// sample_period ticks have passed since the previous one.
// An accepted tick is loaded into the input register; unless the result register
// is stalled, its result is then loaded into the result register and out_valid
// rises. Throughput is one tick per cycle while out_ready does not stall it:
// the control law is a single pass of three parallel 17x18 multiplies, an
// add, a shift and a clamp between the input register and the result register.
// When out_ready is low the result holds; the input register still takes one
// more tick and then in_ready drops until the result is taken.
// Configuration writes (index 0..3: gain_p, gain_i, gain_d, sample_period) are
// always ready; other indexes are dropped. Write only while the block is idle.
// Reset clears the history, the level and the tick count, and loads the gain
// and period defaults (1.0, 0, 0, 5).
module velocity_pid_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vpid_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] measurement,
	input  logic signed [vpid_pkg::SAMPLE_W-1:0] setpoint,
	input  logic                                 enable,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [vpid_pkg::LEVEL_W-1:0]         drive_level,
	output logic                                 updated
);

	vpid_pkg::cfg_t cfg;

	logic                                 valid_s1;
	logic signed [vpid_pkg::SAMPLE_W-1:0] meas_s1;
	logic signed [vpid_pkg::SAMPLE_W-1:0] setp_s1;
	logic                                 en_s1;

	logic signed [vpid_pkg::SAMPLE_W-1:0] prev_q;
	logic signed [vpid_pkg::SAMPLE_W-1:0] older_q;
	logic [vpid_pkg::LEVEL_W-1:0]         level_q;
	logic [vpid_pkg::COUNT_W-1:0]         ticks_q;

	logic                                 out_valid_q;
	logic [vpid_pkg::LEVEL_W-1:0]         drive_level_q;
	logic                                 updated_q;

	logic                                 advance;
	logic [vpid_pkg::COUNT_W-1:0]         ticks_inc;
	logic                                 fire;
	logic [vpid_pkg::LEVEL_W-1:0]         law_level;
	logic [vpid_pkg::LEVEL_W-1:0]         level_next;

	vpid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vpid_law u_law (
		.x          (meas_s1),
		.sp         (setp_s1),
		.prev       (prev_q),
		.older      (older_q),
		.level      (level_q),
		.en         (en_s1),
		.cfg        (cfg),
		.level_next (law_level)
	);

	// the held tick moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// saturate the count, then fire once it reaches the period
	assign ticks_inc  = (&ticks_q) ? ticks_q : ticks_q + 1'b1;
	assign fire       = ticks_inc >= cfg.sample_period;
	assign level_next = fire ? law_level : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1 <= measurement;
			setp_s1 <= setpoint;
			en_s1   <= enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			older_q <= '0;
			level_q <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			level_q <= level_next;
			ticks_q <= fire ? '0 : ticks_inc;
			if (fire) begin
				older_q <= prev_q;
				prev_q  <= meas_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_level_q <= level_next;
			updated_q     <= fire;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = drive_level_q;
	assign updated     = updated_q;

endmodule
